FILE: rtl/btc_pkg.sv
// shared types, constants and rounding and saturation helpers for the barometric trim compensation block
package btc_pkg;

	localparam int OUT_FRAC_BITS_DEF = 16;
	localparam int RAW_W             = 24;
	localparam int TEMP_W            = 24;
	localparam int PRES_W            = 27;
	localparam int CFG_DATA_W        = 48;
	localparam int ACC_W             = 58;
	localparam int RND_W             = 112;
	localparam int QUEUE_DEPTH       = 4;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t                  TEMP_HI  = acc_t'(2**(TEMP_W-1) - 1);
	localparam acc_t                  TEMP_LO  = acc_t'(-(2**(TEMP_W-1)));
	localparam logic [PRES_W-1:0]     PRES_MAX = '1;

	typedef enum logic [1:0] {
		CFG_TEMP_TRIM,
		CFG_PRES_TRIM_A,
		CFG_PRES_TRIM_B,
		CFG_PRES_TRIM_C
	} cfg_index_t;

	typedef struct packed {
		logic signed [7:0] t3;
		logic [15:0]       t2;
		logic [15:0]       t1;
	} temp_trim_t;

	typedef struct packed {
		logic signed [7:0]  p4;
		logic signed [7:0]  p3;
		logic signed [15:0] p2;
		logic signed [15:0] p1;
	} pres_trim_a_t;

	typedef struct packed {
		logic signed [7:0] p8;
		logic signed [7:0] p7;
		logic [15:0]       p6;
		logic [15:0]       p5;
	} pres_trim_b_t;

	typedef struct packed {
		logic signed [7:0]  p11;
		logic signed [7:0]  p10;
		logic signed [15:0] p9;
	} pres_trim_c_t;

	typedef struct packed {
		pres_trim_c_t c;
		pres_trim_b_t b;
		pres_trim_a_t a;
		temp_trim_t   t;
	} trim_t;

	// what the front hands to the pressure path
	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [TEMP_W-1:0] temp_int;
		logic [RAW_W-1:0]         raw_pressure;
	} btc_item_t;

	// x / 2^sh, rounded to nearest with halves away from zero
	function automatic acc_t round_shift(input logic signed [RND_W-1:0] x, input int unsigned sh);
		logic signed [RND_W-1:0] sum;
		sum = x + (RND_W'(1) << (sh - 1));
		if (x[RND_W-1]) begin
			sum = sum - RND_W'(1);
		end
		sum = sum >>> sh;
		return acc_t'(sum);
	endfunction

	function automatic logic signed [TEMP_W-1:0] sat_temp(input acc_t v);
		logic signed [TEMP_W-1:0] r;
		if (v > TEMP_HI) begin
			r = {1'b0, {(TEMP_W-1){1'b1}}};
		end else if (v < TEMP_LO) begin
			r = {1'b1, {(TEMP_W-1){1'b0}}};
		end else begin
			r = TEMP_W'(v);
		end
		return r;
	endfunction

endpackage

FILE: rtl/btc_if.sv
// channel interfaces: sample input, result output and trim register writes
interface btc_in_if;
	logic                       valid;
	logic                       ready;
	logic [btc_pkg::RAW_W-1:0] raw_temperature;
	logic [btc_pkg::RAW_W-1:0] raw_pressure;

	modport source(output valid, output raw_temperature, output raw_pressure, input ready);
	modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [btc_pkg::TEMP_W-1:0]  temperature;
	logic [btc_pkg::PRES_W-1:0]         pressure;
	logic                               pressure_clipped;

	modport source(output valid, output temperature, output pressure,
		output pressure_clipped, input ready);
	modport sink(input valid, input temperature, input pressure,
		input pressure_clipped, output ready);
endinterface

interface btc_cfg_if;
	logic                            valid;
	logic                            ready;
	btc_pkg::cfg_index_t             index;
	logic [btc_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/btc_front.sv
// front end: takes samples and works out compensated and internal temperature
module btc_front #(
	parameter int OUT_FRAC_BITS = btc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btc_pkg::temp_trim_t trim,
	btc_in_if.sink              sample,
	output logic                push,
	output btc_pkg::btc_item_t  push_item,
	input  logic                queue_full
);
	import btc_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [25:0]       d_s1;
	logic [RAW_W-1:0]         up_s1, up_s2, up_s3, up_s4;
	logic signed [42:0]       m1_s2;
	logic signed [51:0]       dd_s2;
	logic signed [61:0]       tnum_s3;
	logic signed [TEMP_W-1:0] tout_s4, tq_s4;

	logic signed [16:0] t2x;
	logic signed [59:0] ddt;

	assign en           = ~v_s4 | ~queue_full;
	assign sample.ready = en;
	assign push         = v_s4 & ~queue_full;
	assign push_item    = '{temperature: tout_s4, temp_int: tq_s4, raw_pressure: up_s4};

	assign t2x = $signed({1'b0, trim.t2});
	assign ddt = dd_s2 * trim.t3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= $signed({2'b00, sample.raw_temperature}) - $signed({2'b00, trim.t1, 8'h00});
			up_s1   <= sample.raw_pressure;
			m1_s2   <= d_s1 * t2x;
			dd_s2   <= d_s1 * d_s1;
			up_s2   <= up_s1;
			tnum_s3 <= (62'(m1_s2) <<< 18) + 62'(ddt);
			up_s3   <= up_s2;
			tout_s4 <= sat_temp(round_shift(RND_W'(tnum_s3), 48 - OUT_FRAC_BITS));
			tq_s4   <= sat_temp(round_shift(RND_W'(tnum_s3), 32));
			up_s4   <= up_s3;
		end
	end

endmodule

FILE: rtl/btc_queue.sv
// short queue between the temperature front end and the pressure back end
module btc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  btc_pkg::btc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output btc_pkg::btc_item_t pop_item,
	output logic               empty
);
	import btc_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	btc_item_t        slot_q [QUEUE_DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full     = cnt_q == CW'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_item = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/btc_wmul.sv
// wide signed multiplier split into four partial products over three stages
module btc_wmul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int PW = AW + BW;
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;

	logic signed [AL:0]   a_lo;
	logic signed [AH-1:0] a_hi;
	logic signed [BL:0]   b_lo;
	logic signed [BH-1:0] b_hi;

	logic signed [AL+BL+1:0] ll_s1;
	logic signed [AL+BH:0]   lh_s1;
	logic signed [AH+BL:0]   hl_s1;
	logic signed [AH+BH-1:0] hh_s1;
	logic signed [PW-1:0]    lo_s2, hi_s2, p_s3;

	assign a_lo = $signed({1'b0, a[AL-1:0]});
	assign a_hi = a[AW-1:AL];
	assign b_lo = $signed({1'b0, b[BL-1:0]});
	assign b_hi = b[BW-1:BL];
	assign p    = p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a_lo * b_lo;
			lh_s1 <= a_lo * b_hi;
			hl_s1 <= a_hi * b_lo;
			hh_s1 <= a_hi * b_hi;
			lo_s2 <= PW'(ll_s1) + (PW'(lh_s1) <<< BL);
			hi_s2 <= PW'(hl_s1) + (PW'(hh_s1) <<< BL);
			p_s3  <= lo_s2 + (hi_s2 <<< AL);
		end
	end

endmodule

FILE: rtl/btc_back.sv
// back end: pressure polynomial, scaling to hPa, saturation and result register
module btc_back #(
	parameter int OUT_FRAC_BITS = btc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btc_pkg::trim_t     trim,
	input  logic               queue_empty,
	input  btc_pkg::btc_item_t queue_item,
	output logic               queue_pop,
	btc_out_if.source          result
);
	import btc_pkg::*;

	localparam int NST = 13;
	localparam int K   = 32 - OUT_FRAC_BITS;
	localparam int QW  = ACC_W - K;
	localparam acc_t          P_HALF    = acc_t'(64'd50 << K);
	localparam logic [QW-1:0] P_LIM     = QW'(64'd100 << PRES_W);
	localparam logic [32:0]   DIV_RECIP = 33'd5497558138;

	logic           en;
	logic [NST:1]   v_q;

	logic signed [TEMP_W-1:0] tout_s1, tout_s2, tout_s3, tout_s4, tout_s5, tout_s6;
	logic signed [TEMP_W-1:0] tout_s7, tout_s8, tout_s9, tout_s10, tout_s11, tout_s12;
	logic signed [TEMP_W-1:0] tout_s13;
	logic signed [TEMP_W-1:0] tq_s1, tq_s2, tq_s3;
	logic signed [RAW_W:0]    up_s1, up_s2, up_s3;

	logic signed [47:0] t2_s2, t2_s3;
	logic signed [48:0] up2_s2, utq_s2;
	logic signed [40:0] a2_s2, a2_s3;
	logic signed [41:0] a5_s2, a5_s3, u6_s2;
	logic signed [31:0] p8tq_s2;

	logic signed [55:0] p3t2_s3, a3_s3;
	logic signed [56:0] upp4tq_s3, up2p10_s3, up2p11_s3;

	logic signed [79:0]  m4;
	logic signed [65:0]  m6;
	logic signed [64:0]  m9;
	logic signed [80:0]  m7, m10;
	logic signed [104:0] m8;
	logic signed [81:0]  m11;

	acc_t sa_s4, r3_s4, a5_s4, sb_s5, sb_s6, r4_s6, r6_s6, r9_s6;
	acc_t sc_s7, r9_s7, r7_s7, r8_s7, r10_s7, r11_s7, sd_s8, se_s8, acc_s9;

	logic              neg_s10, neg_s11, neg_s12;
	logic [QW-1:0]     qsh_s10;
	logic              big_s11, big_s12;
	logic [31:0]       qd_s11, qd_s12;
	logic [64:0]       prod_s12;
	logic [PRES_W-1:0] pressure_s13;
	logic              clip_s13;

	logic signed [16:0] p1x, p2x, p6x;
	acc_t               biased;
	logic [PRES_W-1:0]  quo, quo_fix;
	logic [31:0]        rem;

	assign en        = ~v_q[NST] | result.ready;
	assign queue_pop = ~queue_empty & en;

	assign p1x = {trim.a.p1[15], trim.a.p1} - 17'sd16384;
	assign p2x = {trim.a.p2[15], trim.a.p2} - 17'sd16384;
	assign p6x = $signed({1'b0, trim.b.p6});

	assign biased = acc_s9 + P_HALF;

	// quotient estimate is low by at most one
	assign quo     = prod_s12[63:37];
	assign rem     = qd_s12 - 32'(quo) * 32'd25;
	assign quo_fix = quo + PRES_W'(rem >= 32'd25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-1:1], queue_pop};
		end
	end

	btc_wmul #(.AW(32), .BW(48)) u_m4 (.clk(clk), .en(en), .a(p8tq_s2), .b(t2_s2), .p(m4));
	btc_wmul #(.AW(42), .BW(24)) u_m6 (.clk(clk), .en(en), .a(u6_s2), .b(tq_s2), .p(m6));
	btc_wmul #(.AW(49), .BW(16)) u_m9 (.clk(clk), .en(en), .a(up2_s2), .b(trim.c.p9), .p(m9));
	btc_wmul #(.AW(56), .BW(25)) u_m7 (.clk(clk), .en(en), .a(p3t2_s3), .b(up_s3), .p(m7));
	btc_wmul #(.AW(57), .BW(48)) u_m8 (.clk(clk), .en(en), .a(upp4tq_s3), .b(t2_s3), .p(m8));
	btc_wmul #(.AW(57), .BW(24)) u_m10 (.clk(clk), .en(en), .a(up2p10_s3), .b(tq_s3),
		.p(m10));
	btc_wmul #(.AW(57), .BW(25)) u_m11 (.clk(clk), .en(en), .a(up2p11_s3), .b(up_s3),
		.p(m11));

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: head of queue
			tout_s1 <= queue_item.temperature;
			tq_s1   <= queue_item.temp_int;
			up_s1   <= $signed({1'b0, queue_item.raw_pressure});

			// s2: first-level products
			t2_s2   <= tq_s1 * tq_s1;
			up2_s2  <= up_s1 * up_s1;
			a2_s2   <= p6x * tq_s1;
			a5_s2   <= up_s1 * p1x;
			u6_s2   <= up_s1 * p2x;
			p8tq_s2 <= trim.b.p8 * tq_s1;
			utq_s2  <= up_s1 * tq_s1;
			tq_s2   <= tq_s1;
			up_s2   <= up_s1;
			tout_s2 <= tout_s1;

			// s3: products with the byte-wide trims
			p3t2_s3   <= trim.a.p3 * t2_s2;
			a3_s3     <= trim.b.p7 * t2_s2;
			upp4tq_s3 <= trim.a.p4 * utq_s2;
			up2p10_s3 <= trim.c.p10 * up2_s2;
			up2p11_s3 <= trim.c.p11 * up2_s2;
			t2_s3     <= t2_s2;
			tq_s3     <= tq_s2;
			up_s3     <= up_s2;
			a2_s3     <= a2_s2;
			a5_s3     <= a5_s2;
			tout_s3   <= tout_s2;

			// s4 to s9: rounding and summing of the terms
			sa_s4   <= (acc_t'($signed({1'b0, trim.b.p5})) <<< 35) + (acc_t'(a2_s3) <<< 10);
			r3_s4   <= round_shift(RND_W'(a3_s3), 8);
			a5_s4   <= acc_t'(a5_s3);
			tout_s4 <= tout_s3;

			sb_s5   <= sa_s4 + (a5_s4 <<< 12) + r3_s4;
			tout_s5 <= tout_s4;

			sb_s6   <= sb_s5;
			r4_s6   <= round_shift(RND_W'(m4), 31);
			r6_s6   <= round_shift(RND_W'(m6), 13);
			r9_s6   <= round_shift(RND_W'(m9), 16);
			tout_s6 <= tout_s5;

			sc_s7   <= sb_s6 + r4_s6 + r6_s6;
			r9_s7   <= r9_s6;
			r7_s7   <= round_shift(RND_W'(m7), 32);
			r8_s7   <= round_shift(RND_W'(m8), 53);
			r10_s7  <= round_shift(RND_W'(m10), 32);
			r11_s7  <= round_shift(RND_W'(m11), 33);
			tout_s7 <= tout_s6;

			sd_s8   <= sc_s7 + r9_s7 + r7_s7;
			se_s8   <= r8_s7 + r10_s7 + r11_s7;
			tout_s8 <= tout_s7;

			acc_s9  <= sd_s8 + se_s8;
			tout_s9 <= tout_s8;

			// s10 to s13: scale to hPa with half-up rounding, divide by 100 and clip
			neg_s10  <= acc_s9[ACC_W-1];
			qsh_s10  <= biased[ACC_W-1:K];
			tout_s10 <= tout_s9;

			neg_s11  <= neg_s10;
			big_s11  <= qsh_s10 >= P_LIM;
			qd_s11   <= qsh_s10[33:2];
			tout_s11 <= tout_s10;

			neg_s12  <= neg_s11;
			big_s12  <= big_s11;
			qd_s12   <= qd_s11;
			prod_s12 <= qd_s11 * DIV_RECIP;
			tout_s12 <= tout_s11;

			tout_s13     <= tout_s12;
			clip_s13     <= neg_s12 | big_s12;
			pressure_s13 <= neg_s12 ? '0 : (big_s12 ? PRES_MAX : quo_fix);
		end
	end

	assign result.valid            = v_q[NST];
	assign result.temperature      = tout_s13;
	assign result.pressure         = pressure_s13;
	assign result.pressure_clipped = clip_s13;

endmodule

FILE: rtl/barometric_trim_compensation.sv
// top level of the barometric trim compensation block: trim registers and pipeline
//
//  channel | role   | transfer when       | payload
//  --------+--------+---------------------+---------------------------------------------
//  cfg     | sink   | cfg.valid           | index, data (trim word, low bits used)
//  sample  | sink   | valid && ready      | raw_temperature, raw_pressure
//  result  | source | valid && ready      | temperature, pressure, pressure_clipped
//
// one sample per cycle in and one result per cycle out when the result side keeps up.
// a sample transfer loads the first of 4 front stages; the sample then passes through
// one queue entry and the 13 stages of the pressure back end before result valid.
// a four-entry queue joins the two halves, so the front keeps taking samples while
// results wait; sample.ready drops once the queue is full and the front is holding a sample.
// reset clears all trim words to zero and empties the pipeline and queue.
module barometric_trim_compensation #(
	parameter int OUT_FRAC_BITS = btc_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btc_cfg_if.sink    cfg,
	btc_in_if.sink     sample,
	btc_out_if.source  result
);
	import btc_pkg::*;

	trim_t     trim_q;
	logic      push, queue_full, queue_pop, queue_empty;
	btc_item_t push_item, queue_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TEMP_TRIM:   trim_q.t <= temp_trim_t'(cfg.data[39:0]);
				CFG_PRES_TRIM_A: trim_q.a <= pres_trim_a_t'(cfg.data[47:0]);
				CFG_PRES_TRIM_B: trim_q.b <= pres_trim_b_t'(cfg.data[47:0]);
				CFG_PRES_TRIM_C: trim_q.c <= pres_trim_c_t'(cfg.data[31:0]);
				default: ;
			endcase
		end
	end

	btc_front #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.trim       (trim_q.t),
		.sample     (sample),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	btc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_item  (queue_item),
		.empty     (queue_empty)
	);

	btc_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.trim        (trim_q),
		.queue_empty (queue_empty),
		.queue_item  (queue_item),
		.queue_pop   (queue_pop),
		.result      (result)
	);

endmodule
